// ===== sv/collision_triangle_setup_defines.svh =====
// Assertion macros used by the checker file of the triangle setup block.
`ifndef COLLISION_TRIANGLE_SETUP_DEFINES_SVH
`define COLLISION_TRIANGLE_SETUP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CTS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cts_pkg.sv =====
// Types, constants and helper functions of the triangle setup block.
package cts_pkg;

	localparam int CELL_SIZE_DEF  = 1024;
	localparam int GRID_CELLS_DEF = 16;

	localparam logic [15:0] CELL_BIAS   = 16'h2000;
	localparam int          LOW_MARGIN  = 50;
	localparam int          HIGH_MARGIN = 49;
	localparam logic signed [16:0] Y_WIDEN = 17'sd5;

	localparam logic signed [15:0] FLOOR_LIMIT     = 16'sd164;
	localparam logic signed [15:0] NEG_FLOOR_LIMIT = -16'sd164;
	localparam logic signed [15:0] XWALL_LIMIT     = 16'sd11584;
	localparam logic signed [15:0] NEG_XWALL_LIMIT = -16'sd11584;

	localparam int SQ_IN_W   = 62;
	localparam int SQ_W      = 63;
	localparam int SQ_ROOT_W = 31;
	localparam int SQ_STEPS  = 32;

	localparam int DIV_NUM_W = 46;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_Q_W   = 15;

	localparam int PIPE_LAT = 59;

	typedef enum logic [1:0] {
		CLS_FLOOR   = 2'd0,
		CLS_CEILING = 2'd1,
		CLS_WALL_Z  = 2'd2,
		CLS_WALL_X  = 2'd3
	} surf_class_t;

	typedef logic signed [15:0] coord_t;

	typedef struct packed {
		coord_t              x1;
		coord_t              y1;
		coord_t              z1;
		logic signed [16:0]  lower_y;
		logic signed [16:0]  upper_y;
		logic [4:0]          cxl;
		logic [3:0]          cxh;
		logic [4:0]          czl;
		logic [3:0]          czh;
		logic [2:0]          neg;
		logic                zero;
	} side_t;

	function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
		coord_t m;
		m = a;
		if (b < m) m = b;
		if (c < m) m = c;
		return m;
	endfunction

	function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
		coord_t m;
		m = a;
		if (b > m) m = b;
		if (c > m) m = c;
		return m;
	endfunction

endpackage

// ===== sv/cts_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module cts_sqrt (
	input  logic                           clk,
	input  logic [cts_pkg::SQ_IN_W-1:0]    radicand,
	output logic [cts_pkg::SQ_ROOT_W-1:0]  root
);
	import cts_pkg::*;

	logic [SQ_W-1:0] rem_s  [0:SQ_STEPS];
	logic [SQ_W-1:0] root_s [0:SQ_STEPS];

	assign rem_s[0]  = SQ_W'(radicand);
	assign root_s[0] = '0;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQ_W-1:0] trial;
		assign trial = root_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= (root_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
		end
	end

	assign root = root_s[SQ_STEPS][SQ_ROOT_W-1:0];

endmodule

// ===== sv/cts_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module cts_div (
	input  logic                          clk,
	input  logic [cts_pkg::DIV_NUM_W-1:0] num,
	input  logic [cts_pkg::DIV_DEN_W-1:0] den,
	output logic [cts_pkg::DIV_Q_W-1:0]   quot
);
	import cts_pkg::*;

	logic [DIV_NUM_W-1:0] rem_s [0:DIV_Q_W];
	logic [DIV_DEN_W-1:0] den_s [0:DIV_Q_W];
	logic [DIV_Q_W-1:0]   quo_s [0:DIV_Q_W];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
		localparam int SH = DIV_Q_W - 1 - k;
		logic [DIV_NUM_W-1:0] dsh;
		assign dsh = DIV_NUM_W'(den_s[k]) << SH;
		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			if (rem_s[k] >= dsh) begin
				rem_s[k+1] <= rem_s[k] - dsh;
				quo_s[k+1] <= {quo_s[k][DIV_Q_W-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= rem_s[k];
				quo_s[k+1] <= {quo_s[k][DIV_Q_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_s[DIV_Q_W];

endmodule

// ===== sv/collision_triangle_setup.sv =====
// Collision triangle setup: plane normal, offset, class, vertical bounds and grid cell range.
//
// A request is taken at every rising edge where start is high and busy is
// low. busy is always low: the pipeline takes one triangle every cycle.
// Each request yields exactly one result, shown for a single cycle with done
// high; done and the result fields are registered together from the last
// pipeline stage. Results leave in request order.
// The latency is set by the 32-stage square root and the 15-stage divider
// that normalize the cross product; every other step takes one stage.
// The receiver cannot hold results off, so nothing ever stalls.
// A degenerate triangle (zero cross product) gives valid_res low and all
// other result fields zero.
// An asynchronous reset clears every valid bit in the pipeline, so requests
// in flight at reset produce no result.
// CELL_SIZE must be a power of two.
module collision_triangle_setup #(
	parameter int CELL_SIZE  = cts_pkg::CELL_SIZE_DEF,
	parameter int GRID_CELLS = cts_pkg::GRID_CELLS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [15:0]      v1_x,
	input  logic signed [15:0]      v1_y,
	input  logic signed [15:0]      v1_z,
	input  logic signed [15:0]      v2_x,
	input  logic signed [15:0]      v2_y,
	input  logic signed [15:0]      v2_z,
	input  logic signed [15:0]      v3_x,
	input  logic signed [15:0]      v3_y,
	input  logic signed [15:0]      v3_z,
	output logic                    done,
	output logic                    valid_res,
	output logic [1:0]              surface_class,
	output logic signed [15:0]      normal_x,
	output logic signed [15:0]      normal_y,
	output logic signed [15:0]      normal_z,
	output logic signed [16:0]      plane_offset,
	output logic signed [16:0]      lower_y,
	output logic signed [16:0]      upper_y,
	output logic [4:0]              cell_x_low,
	output logic [3:0]              cell_x_high,
	output logic [4:0]              cell_z_low,
	output logic [3:0]              cell_z_high
);
	import cts_pkg::*;

	localparam int CELL_BITS = $clog2(CELL_SIZE);
	localparam logic [14:0] CELL_MASK = 15'(CELL_SIZE - 1);
	localparam logic [14:0] HIGH_EDGE = 15'(CELL_SIZE - HIGH_MARGIN);
	localparam logic [15:0] LAST_CELL = 16'(GRID_CELLS - 1);
	localparam int LAST = PIPE_LAT - 1;

	function automatic logic [14:0] cell_pos(coord_t c);
		logic [15:0] u;
		u = 16'(c) + CELL_BIAS;
		return u[15] ? 15'd0 : u[14:0];
	endfunction

	function automatic logic [4:0] cell_low(coord_t c);
		logic [14:0] t;
		logic [14:0] i;
		t = cell_pos(c);
		i = t >> CELL_BITS;
		if ((t & CELL_MASK) < 15'(LOW_MARGIN) && i != 15'd0)
			i = i - 15'd1;
		return i[4:0];
	endfunction

	function automatic logic [3:0] cell_high(coord_t c);
		logic [14:0] t;
		logic [15:0] i;
		t = cell_pos(c);
		i = 16'(t >> CELL_BITS);
		if ((t & CELL_MASK) >= HIGH_EDGE)
			i = i + 16'd1;
		if (i > LAST_CELL)
			i = LAST_CELL;
		return i[3:0];
	endfunction

	logic in_fire;
	assign busy    = 1'b0;
	assign in_fire = start && !busy;

	logic [LAST:1] vld_s;
	side_t side_s [1:LAST];
	side_t side_in, side3_n, side5_n;

	logic signed [16:0] dx21, dy21, dz21, dx32, dy32, dz32;
	assign dx21 = 17'(v2_x) - 17'(v1_x);
	assign dy21 = 17'(v2_y) - 17'(v1_y);
	assign dz21 = 17'(v2_z) - 17'(v1_z);
	assign dx32 = 17'(v3_x) - 17'(v2_x);
	assign dy32 = 17'(v3_y) - 17'(v2_y);
	assign dz32 = 17'(v3_z) - 17'(v2_z);

	coord_t ymin, ymax;
	assign ymin = min3(v1_y, v2_y, v3_y);
	assign ymax = max3(v1_y, v2_y, v3_y);

	always_comb begin
		side_in         = '0;
		side_in.x1      = v1_x;
		side_in.y1      = v1_y;
		side_in.z1      = v1_z;
		side_in.lower_y = 17'(ymin) - Y_WIDEN;
		side_in.upper_y = 17'(ymax) + Y_WIDEN;
		side_in.cxl     = cell_low(min3(v1_x, v2_x, v3_x));
		side_in.cxh     = cell_high(max3(v1_x, v2_x, v3_x));
		side_in.czl     = cell_low(min3(v1_z, v2_z, v3_z));
		side_in.czh     = cell_high(max3(v1_z, v2_z, v3_z));
	end

	logic signed [33:0] pr_s1 [6];
	logic signed [34:0] c_s2  [3];
	logic [33:0]        a_s3  [3];
	logic [33:0]        a_s4  [3];
	logic [33:0]        m_s4;
	logic [33:0]        a_s5  [3];
	logic               shl_s5;
	logic [4:0]         amt_s5;
	logic [29:0]        an_s  [6:40][3];
	logic [59:0]        sq_s7 [3];
	logic [61:0]        sum_s8;

	logic [5:0] lead;
	logic [4:0] amt_n;

	always_comb begin
		lead = '0;
		for (int i = 0; i < 34; i++)
			if (m_s4[i]) lead = 6'(i);
		amt_n = (lead < 6'd29) ? 5'(6'd29 - lead) : 5'(lead - 6'd29);
	end

	always_comb begin
		side3_n = side_s[2];
		for (int i = 0; i < 3; i++)
			side3_n.neg[i] = c_s2[i][34];
		side5_n = side_s[4];
		side5_n.zero = (m_s4 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[LAST-1:1], in_fire};
			done  <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		pr_s1[0] <= 34'(dy21) * 34'(dz32);
		pr_s1[1] <= 34'(dz21) * 34'(dy32);
		pr_s1[2] <= 34'(dz21) * 34'(dx32);
		pr_s1[3] <= 34'(dx21) * 34'(dz32);
		pr_s1[4] <= 34'(dx21) * 34'(dy32);
		pr_s1[5] <= 34'(dy21) * 34'(dx32);
		side_s[1] <= side_in;
		for (int k = 2; k <= LAST; k++)
			if (k != 3 && k != 5)
				side_s[k] <= side_s[k-1];
		side_s[3] <= side3_n;
		side_s[5] <= side5_n;

		for (int i = 0; i < 3; i++) begin
			c_s2[i] <= 35'(pr_s1[2*i]) - 35'(pr_s1[2*i+1]);
			a_s3[i] <= c_s2[i][34] ? 34'(-c_s2[i]) : 34'(c_s2[i]);
			a_s4[i] <= a_s3[i];
			a_s5[i] <= a_s4[i];
			an_s[6][i] <= shl_s5 ? 30'(a_s5[i] << amt_s5) : 30'(a_s5[i] >> amt_s5);
			sq_s7[i] <= 60'(an_s[6][i]) * 60'(an_s[6][i]);
		end
		m_s4 <= (a_s3[0] > a_s3[1]) ?
			((a_s3[0] > a_s3[2]) ? a_s3[0] : a_s3[2]) :
			((a_s3[1] > a_s3[2]) ? a_s3[1] : a_s3[2]);
		shl_s5 <= (lead < 6'd29);
		amt_s5 <= amt_n;
		for (int k = 7; k <= 40; k++)
			an_s[k] <= an_s[k-1];
		sum_s8 <= 62'(sq_s7[0]) + 62'(sq_s7[1]) + 62'(sq_s7[2]);
	end

	logic [SQ_ROOT_W-1:0] root_s40;

	cts_sqrt u_sqrt (
		.clk      (clk),
		.radicand (sum_s8),
		.root     (root_s40)
	);

	logic [DIV_Q_W-1:0] quot_s55 [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
		assign num = DIV_NUM_W'({an_s[40][i], 15'd0}) + DIV_NUM_W'(root_s40);
		assign den = {root_s40, 1'b0};
		cts_div u_div (
			.clk  (clk),
			.num  (num),
			.den  (den),
			.quot (quot_s55[i])
		);
	end

	logic signed [15:0] q_s56  [3];
	logic signed [15:0] q_s57  [3];
	logic signed [15:0] q_s58  [3];
	logic signed [31:0] dp_s57 [3];
	logic signed [33:0] d_s58;
	surf_class_t        cls_s57, cls_s58, cls_n;

	always_comb begin
		if (q_s56[1] > FLOOR_LIMIT)
			cls_n = CLS_FLOOR;
		else if (q_s56[1] < NEG_FLOOR_LIMIT)
			cls_n = CLS_CEILING;
		else if (q_s56[0] > XWALL_LIMIT || q_s56[0] < NEG_XWALL_LIMIT)
			cls_n = CLS_WALL_X;
		else
			cls_n = CLS_WALL_Z;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			q_s56[i] <= side_s[55].neg[i] ? -signed'(16'(quot_s55[i])) :
				signed'(16'(quot_s55[i]));
			q_s57[i] <= q_s56[i];
			q_s58[i] <= q_s57[i];
		end
		dp_s57[0] <= 32'(q_s56[0]) * 32'(side_s[56].x1);
		dp_s57[1] <= 32'(q_s56[1]) * 32'(side_s[56].y1);
		dp_s57[2] <= 32'(q_s56[2]) * 32'(side_s[56].z1);
		cls_s57 <= cls_n;
		cls_s58 <= cls_s57;
		d_s58 <= 34'(dp_s57[0]) + 34'(dp_s57[1]) + 34'(dp_s57[2]);
	end

	logic [33:0]        ad;
	logic signed [16:0] offm;
	assign ad   = d_s58[33] ? 34'(-d_s58) : 34'(d_s58);
	assign offm = signed'(17'((ad + 34'd8192) >> 14));

	always_ff @(posedge clk) begin
		if (side_s[LAST].zero) begin
			valid_res     <= 1'b0;
			surface_class <= '0;
			normal_x      <= '0;
			normal_y      <= '0;
			normal_z      <= '0;
			plane_offset  <= '0;
			lower_y       <= '0;
			upper_y       <= '0;
			cell_x_low    <= '0;
			cell_x_high   <= '0;
			cell_z_low    <= '0;
			cell_z_high   <= '0;
		end else begin
			valid_res     <= 1'b1;
			surface_class <= cls_s58;
			normal_x      <= q_s58[0];
			normal_y      <= q_s58[1];
			normal_z      <= q_s58[2];
			plane_offset  <= (d_s58 > 34'sd0) ? -offm : offm;
			lower_y       <= side_s[LAST].lower_y;
			upper_y       <= side_s[LAST].upper_y;
			cell_x_low    <= side_s[LAST].cxl;
			cell_x_high   <= side_s[LAST].cxh;
			cell_z_low    <= side_s[LAST].czl;
			cell_z_high   <= side_s[LAST].czh;
		end
	end

endmodule

// ===== sv/cts_checker.sv =====
// Port-level checker of the triangle setup block and its bind statement.
`include "collision_triangle_setup_defines.svh"

module cts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               valid_res,
	input logic [1:0]         surface_class,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic signed [16:0] plane_offset,
	input logic signed [16:0] lower_y,
	input logic signed [16:0] upper_y,
	input logic [4:0]         cell_x_low,
	input logic [3:0]         cell_x_high,
	input logic [4:0]         cell_z_low,
	input logic [3:0]         cell_z_high
);
	import cts_pkg::*;

	logic res_ok, is_floor, degen_clear;
	assign res_ok   = done && valid_res;
	assign is_floor = res_ok && surface_class == CLS_FLOOR;
	assign degen_clear = surface_class == '0 && normal_x == '0 && normal_y == '0 &&
		normal_z == '0 && plane_offset == '0 && lower_y == '0 && upper_y == '0 &&
		cell_x_low == '0 && cell_x_high == '0 && cell_z_low == '0 &&
		cell_z_high == '0;

	`CTS_ASSERT_NEXT(a_req_to_done, start && !busy, ##(PIPE_LAT-1) done, "request lost")
	`CTS_ASSERT_IMPL(a_done_had_req, done, $past(start && !busy, PIPE_LAT), "result without request")
	`CTS_ASSERT_IMPL(a_degen_zero, done && !valid_res, degen_clear, "degenerate result not cleared")
	`CTS_ASSERT_IMPL(a_y_span, res_ok, lower_y < upper_y, "vertical bounds out of order")
	`CTS_ASSERT_IMPL(a_floor_up, is_floor, normal_y > FLOOR_LIMIT, "floor without upward normal")

endmodule

bind collision_triangle_setup cts_checker u_cts_checker (.*);
